FILE: hw/rtl/cv2d_pkg.sv
// Shared constants, types and command/status bundles for the 2D convolution block.
package cv2d_pkg;

    // Sizing
    localparam int MAX_SIDE    = 256;
    localparam int MAX_RADIUS  = 2;
    localparam int KSIDE       = 2 * MAX_RADIUS + 1;
    localparam int NTAPS       = KSIDE * KSIDE;
    localparam int FRAME_DEPTH = MAX_SIDE * MAX_SIDE;

    // Derived internal widths
    localparam int ADDR_W   = $clog2(FRAME_DEPTH);
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
    localparam int KW       = $clog2(KSIDE);
    localparam int TAP_W    = $clog2(NTAPS);
    localparam int SZ_W     = 2 * SIDE_W;
    localparam int DIVCNT_W = $clog2(ADDR_W);

    // Port field widths
    localparam int KIND_W     = 2;
    localparam int TAP_IDX_W  = 5;
    localparam int COEF_W     = 18;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int RADIUS_W   = 2;

    // Arithmetic
    localparam int FRAC_W = 16;
    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(NTAPS);

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] SIDE_RST   = 9'd256;
    localparam logic [RADIUS_W-1:0]   RADIUS_RST = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_COEF  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_EMIT  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_TAPS,
        S_DRAIN,
        S_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic coef_wr;
        logic pix_wr;
        logic emit_start;
        logic div_step;
        logic tap_issue;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic xy_ok;
        logic tap_last;
        logic pipe_busy;
        logic out_free;
    } t_stat;

endpackage

FILE: hw/rtl/cv2d_if.sv
// Valid/ready channel interfaces: input items, result items and register writes.
interface cv2d_in_if;
    import cv2d_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [TAP_IDX_W-1:0]     tap_index;
    logic signed [COEF_W-1:0] coeff_value;
    logic [PIX_W-1:0]         pixel_value;
    modport source (output valid, kind, tap_index, coeff_value, pixel_value, input ready);
    modport sink   (input valid, kind, tap_index, coeff_value, pixel_value, output ready);
endinterface

interface cv2d_out_if;
    import cv2d_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             last_pixel;
    modport source (output valid, out_pixel, last_pixel, input ready);
    modport sink   (input valid, out_pixel, last_pixel, output ready);
endinterface

interface cv2d_cfg_if;
    import cv2d_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/cv2d_ctrl.sv
// Control state machine: sequences coordinate recovery, tap sweep, drain and result write.
module cv2d_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [cv2d_pkg::KIND_W-1:0]   i_kind,
    output logic                          o_in_ready,
    output cv2d_pkg::t_cmd                o_cmd,
    input  cv2d_pkg::t_stat               i_stat
);
    import cv2d_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (t_kind'(i_kind))
                        KIND_COEF: begin
                            o_cmd.coef_wr = 1'b1;
                        end
                        KIND_PIXEL: begin
                            o_cmd.pix_wr = 1'b1;
                        end
                        KIND_EMIT: begin
                            o_cmd.emit_start = 1'b1;
                            n_state          = S_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            // recover x,y from the raster address when the width changed
            S_DIV: begin
                if (i_stat.xy_ok) begin
                    n_state = S_TAPS;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            // one tap per cycle into the MAC pipeline
            S_TAPS: begin
                o_cmd.tap_issue = 1'b1;
                if (i_stat.tap_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_FIN;
                end
            end
            // wait for the output register to free up
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cv2d_dp.sv
// Datapath: registers, frame and tap stores, divider, MAC pipeline and output register.
module cv2d_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cv2d_pkg::t_cmd                    i_cmd,
    output cv2d_pkg::t_stat                   o_stat,
    input  logic [cv2d_pkg::TAP_IDX_W-1:0]    i_tap_index,
    input  logic signed [cv2d_pkg::COEF_W-1:0] i_coeff_value,
    input  logic [cv2d_pkg::PIX_W-1:0]        i_pixel_value,
    input  logic                              i_cfg_we,
    input  logic [cv2d_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cv2d_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [cv2d_pkg::PIX_W-1:0]        o_out_pixel,
    output logic                              o_out_last
);
    import cv2d_pkg::*;

    localparam int CW = SIDE_W + 2;
    localparam int FW = COORD_W + SIDE_W;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_DATA_W-1:0] d);
        logic [SIDE_W+CFG_DATA_W-1:0] v;
        v = (SIDE_W + CFG_DATA_W)'(d);
        if (v == '0) begin
            return SIDE_W'(1);
        end else if (v > (SIDE_W + CFG_DATA_W)'(MAX_SIDE)) begin
            return SIDE_W'(MAX_SIDE);
        end
        return SIDE_W'(v);
    endfunction

    function automatic logic [COORD_W-1:0] edge_clamp(input logic signed [CW-1:0] v,
                                                      input logic [SIDE_W-1:0] n);
        logic signed [CW-1:0] top;
        top = $signed(CW'(n - 1'b1));
        if (v < 0) begin
            return '0;
        end else if (v > top) begin
            return COORD_W'(top);
        end
        return COORD_W'(v);
    endfunction

    // Configuration and pointers
    logic [CFG_DATA_W-1:0] r_cfg_w;
    logic [CFG_DATA_W-1:0] r_cfg_h;
    logic [RADIUS_W-1:0]   r_cfg_r;
    logic [ADDR_W-1:0]     r_load_ptr;
    logic [ADDR_W-1:0]     r_emit_ptr;
    logic [COORD_W-1:0]    r_x;
    logic [COORD_W-1:0]    r_y;
    logic                  r_xy_ok;
    logic                  r_last;

    // Divider
    logic [DIVCNT_W-1:0]   r_div_cnt;
    logic [COORD_W-1:0]    r_rem;
    logic [ADDR_W-1:0]     r_quo;

    // Tap sweep and MAC pipeline
    logic [KW-1:0]             r_i;
    logic [KW-1:0]             r_j;
    logic [ADDR_W-1:0]         r_fa;
    logic [TAP_W-1:0]          r_ti;
    logic                      r_v0;
    logic [PIX_W-1:0]          r_pix;
    logic signed [COEF_W-1:0]  r_coef;
    logic                      r_v1;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_v2;
    logic signed [ACC_W-1:0]   r_acc;

    // Output register
    logic                  r_out_valid;
    logic [PIX_W-1:0]      r_out_pixel;
    logic                  r_out_last;

    // Stores
    logic signed [COEF_W-1:0] r_coef_mem [NTAPS];
    logic [PIX_W-1:0]         r_frame_mem [FRAME_DEPTH];

    logic [SIDE_W-1:0]     w;
    logic [SIDE_W-1:0]     h;
    logic [RAD_W-1:0]      rad;
    logic [SZ_W-1:0]       size;
    logic [ADDR_W-1:0]     ld_ptr;
    logic                  ld_last;
    logic [ADDR_W-1:0]     em_ptr;
    logic                  em_wrap;
    logic                  em_last;
    logic [COORD_W:0]      div_t;
    logic                  div_ge;
    logic [COORD_W-1:0]    rem_next;
    logic [ADDR_W-1:0]     quo_next;
    logic [KW-1:0]         kmax;
    logic signed [CW-1:0]  sx_s;
    logic signed [CW-1:0]  sy_s;
    logic [COORD_W-1:0]    sx;
    logic [COORD_W-1:0]    sy;
    logic [FW-1:0]         fa_wide;
    logic [TAP_W-1:0]      ti_calc;
    logic [PIX_W-1:0]      sat_pixel;

    // Effective frame geometry
    always_comb begin
        w    = clamp_side(r_cfg_w);
        h    = clamp_side(r_cfg_h);
        rad  = (int'(r_cfg_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_cfg_r);
        size = SZ_W'(w) * SZ_W'(h);
    end

    // Pointer restart and end-of-frame detection
    always_comb begin
        ld_ptr  = (SZ_W'(r_load_ptr) >= size) ? '0 : r_load_ptr;
        ld_last = (SZ_W'(ld_ptr) == size - SZ_W'(1));
        em_wrap = (SZ_W'(r_emit_ptr) >= size);
        em_ptr  = em_wrap ? '0 : r_emit_ptr;
        em_last = (SZ_W'(em_ptr) == size - SZ_W'(1));
    end

    // Restoring divider step: address / width
    always_comb begin
        div_t    = {r_rem, r_quo[ADDR_W-1]};
        div_ge   = ((SIDE_W + COORD_W)'(div_t) >= (SIDE_W + COORD_W)'(w));
        rem_next = div_ge ? COORD_W'(div_t - w) : COORD_W'(div_t);
        quo_next = {r_quo[ADDR_W-2:0], div_ge};
    end

    // Tap address with replicated borders
    always_comb begin
        kmax    = KW'(rad) + KW'(rad);
        sx_s    = $signed(CW'(r_x)) + $signed(CW'(r_i)) - $signed(CW'(rad));
        sy_s    = $signed(CW'(r_y)) + $signed(CW'(r_j)) - $signed(CW'(rad));
        sx      = edge_clamp(sx_s, w);
        sy      = edge_clamp(sy_s, h);
        fa_wide = FW'(sy) * FW'(w) + FW'(sx);
        ti_calc = TAP_W'(r_i) * TAP_W'(KSIDE) + TAP_W'(r_j);
    end

    // Truncate Q.16 sum and saturate to a byte
    always_comb begin
        if (r_acc[ACC_W-1]) begin
            sat_pixel = '0;
        end else if (|r_acc[ACC_W-2:FRAC_W+PIX_W]) begin
            sat_pixel = '1;
        end else begin
            sat_pixel = r_acc[FRAC_W+PIX_W-1:FRAC_W];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= SIDE_RST;
            r_cfg_h     <= SIDE_RST;
            r_cfg_r     <= RADIUS_RST;
            r_load_ptr  <= '0;
            r_emit_ptr  <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_xy_ok     <= 1'b1;
            r_div_cnt   <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NTAPS; k++) begin
                r_coef_mem[k] <= '0;
            end
        end else begin
            // register writes; a new width invalidates the cached x,y
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_WIDTH: begin
                        r_cfg_w <= i_cfg_data;
                        r_xy_ok <= 1'b0;
                    end
                    REG_HEIGHT: begin
                        r_cfg_h <= i_cfg_data;
                    end
                    REG_RADIUS: begin
                        r_cfg_r <= i_cfg_data[RADIUS_W-1:0];
                    end
                    default: ;
                endcase
            end

            if (i_cmd.coef_wr && (int'(i_tap_index) < NTAPS)) begin
                r_coef_mem[TAP_W'(i_tap_index)] <= i_coeff_value;
            end

            if (i_cmd.pix_wr) begin
                r_load_ptr <= ld_last ? '0 : ld_ptr + 1'b1;
            end

            if (i_cmd.emit_start) begin
                r_emit_ptr <= em_ptr;
                r_div_cnt  <= '0;
                r_i        <= '0;
                r_j        <= '0;
                if (em_wrap) begin
                    r_x     <= '0;
                    r_y     <= '0;
                    r_xy_ok <= 1'b1;
                end
            end

            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == DIVCNT_W'(ADDR_W - 1)) begin
                    r_x     <= rem_next;
                    r_y     <= COORD_W'(quo_next);
                    r_xy_ok <= 1'b1;
                end
            end

            // kernel sweep: dx inner, dy outer
            if (i_cmd.tap_issue) begin
                if (r_i == kmax) begin
                    r_i <= '0;
                    r_j <= r_j + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            r_v0 <= i_cmd.tap_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;

            // result write and raster advance
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_emit_ptr <= '0;
                    r_x        <= '0;
                    r_y        <= '0;
                end else begin
                    r_emit_ptr <= r_emit_ptr + 1'b1;
                    if (SIDE_W'(r_x) + SIDE_W'(1) == w) begin
                        r_x <= '0;
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start) begin
            r_last <= em_last;
            r_quo  <= em_ptr;
            r_rem  <= '0;
            r_acc  <= '0;
        end else begin
            if (i_cmd.div_step) begin
                r_quo <= quo_next;
                r_rem <= rem_next;
            end
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        r_fa   <= fa_wide[ADDR_W-1:0];
        r_ti   <= ti_calc;
        r_coef <= r_coef_mem[r_ti];
        r_prod <= $signed({1'b0, r_pix}) * r_coef;
        if (i_cmd.finish) begin
            r_out_pixel <= sat_pixel;
            r_out_last  <= r_last;
        end
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_wr) begin
            r_frame_mem[ld_ptr] <= i_pixel_value;
        end
        r_pix <= r_frame_mem[r_fa];
    end

    always_comb begin
        o_stat.xy_ok     = r_xy_ok;
        o_stat.tap_last  = (r_i == kmax) && (r_j == kmax);
        o_stat.pipe_busy = r_v0 | r_v1 | r_v2;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_out_last  = r_out_last;

endmodule

FILE: hw/rtl/convolve_2d_clamped_edges.sv
// Top level of the 2D convolution block with replicated borders.
//
// Channels: i_in carries items (kind 0 writes a Q2.16 tap, kind 1 stores the
// next pixel in raster order, kind 2 requests the next filtered pixel; kind 3
// is dropped). o_out carries one result per kind 2 item: the pixel and a flag
// on the final pixel of the frame. i_cfg writes width (0), height (1) and
// kernel radius (2); it is always ready and should only be used while idle.
// Flow: tap and pixel items are accepted whenever the block is idle. A kind 2
// item holds the input until its result is registered: one shared
// multiply-accumulate walks the kernel one tap per cycle, with a four-stage
// address/read/multiply/add pipeline to drain. The first output request after
// a width write also runs a bit-serial divide that recovers x and y
// from the raster address. The result becomes valid in the cycle the input
// turns ready again.
// A result waits in an output register; the next item is taken meanwhile, and
// only the following result write waits on a stalled receiver.
// Reset: taps clear to zero, pointers return to the frame origin, size resets
// to 256 by 256 and radius to 1. Frame contents stay undefined until written.
module convolve_2d_clamped_edges (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cv2d_in_if.sink           i_in,
    cv2d_out_if.source        o_out,
    cv2d_cfg_if.sink          i_cfg
);
    import cv2d_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    cv2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_kind     (i_in.kind),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    cv2d_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_tap_index   (i_in.tap_index),
        .i_coeff_value (i_in.coeff_value),
        .i_pixel_value (i_in.pixel_value),
        .i_cfg_we      (i_cfg.valid && i_cfg.ready),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_pixel   (o_out.out_pixel),
        .o_out_last    (o_out.last_pixel)
    );

endmodule

FILE: tb/tb_convolve_2d_clamped_edges.sv
// Testbench for convolve_2d_clamped_edges: frames, taps and sizes checked against a local predictor.
module tb_convolve_2d_clamped_edges;
    timeunit 1ns;
    timeprecision 1ps;
    import cv2d_pkg::*;

    // Codes the package leaves unnamed: the spare item kind and register index
    localparam logic [KIND_W-1:0]    KIND_NONE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE  = 2'd3;

    localparam logic signed [COEF_W-1:0] COEF_MIN = 18'sh20000;
    localparam logic signed [COEF_W-1:0] COEF_MAX = 18'sh1FFFF;
    localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sh10000;

    // Longest sweep (radius 2) plus the divide after a width write, with margin
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 1300;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_out_pixel;

    // Mirror of the block's state; predicts one filtered pixel per emit transfer
    class conv_frame_checker;
        logic [PIX_W-1:0]         frame_mem [FRAME_DEPTH];
        bit                       written   [FRAME_DEPTH];
        logic signed [COEF_W-1:0] taps      [NTAPS];
        logic [CFG_DATA_W-1:0]    width_reg;
        logic [CFG_DATA_W-1:0]    height_reg;
        logic [RADIUS_W-1:0]      radius_reg;
        int unsigned              load_ptr;
        int unsigned              emit_ptr;
        int unsigned              unwritten;
        t_out_pixel               pending_pixels [$];
        int                       n_checked;
        int                       n_errors;

        function new();
            foreach (taps[i]) taps[i] = '0;
            foreach (written[i]) written[i] = 1'b0;
            width_reg  = SIDE_RST;
            height_reg = SIDE_RST;
            radius_reg = RADIUS_RST;
            load_ptr   = 0;
            emit_ptr   = 0;
            n_checked  = 0;
            n_errors   = 0;
            recount();
        endfunction

        // Out-of-range sizes act as the nearest legal one
        function int side(logic [CFG_DATA_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_SIDE) return MAX_SIDE;
            return int'(v);
        endfunction

        function int unsigned frame_size();
            return side(width_reg) * side(height_reg);
        endfunction

        function int live_radius();
            return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
        endfunction

        // Frame entries inside the current size that were never loaded
        function void recount();
            int unsigned a;
            unwritten = 0;
            for (a = 0; a < frame_size(); a++)
                if (!written[a]) unwritten++;
        endfunction

        function int pin(int v, int n);
            if (v < 0) return 0;
            if (v > n - 1) return n - 1;
            return v;
        endfunction

        // Exact sum over the window with replicated borders, then truncate and saturate
        function logic [PIX_W-1:0] filter_at(int unsigned addr);
            int     w, h, r, x, y, sx, sy, dx, dy;
            longint acc;
            w   = side(width_reg);
            h   = side(height_reg);
            r   = live_radius();
            x   = addr % w;
            y   = addr / w;
            acc = 0;
            for (dy = -r; dy <= r; dy++) begin
                sy = pin(y + dy, h);
                for (dx = -r; dx <= r; dx++) begin
                    sx = pin(x + dx, w);
                    acc += longint'(frame_mem[sy * w + sx]) *
                           longint'(taps[(dx + r) * KSIDE + (dy + r)]);
                end
            end
            if (acc < 0) return '0;
            acc = acc >>> FRAC_W;
            if (acc > 255) return 8'd255;
            return acc[PIX_W-1:0];
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WIDTH:  width_reg  = data;
                REG_HEIGHT: height_reg = data;
                REG_RADIUS: radius_reg = data[RADIUS_W-1:0];
                default: ;
            endcase
            recount();
        endfunction

        function void note_item(logic [KIND_W-1:0] kind, logic [TAP_IDX_W-1:0] tap,
                                logic signed [COEF_W-1:0] coeff, logic [PIX_W-1:0] pix);
            int unsigned size;
            t_out_pixel  e;
            size = frame_size();
            case (kind)
                KIND_COEF: begin
                    if (tap < NTAPS) taps[tap] = coeff;
                end
                KIND_PIXEL: begin
                    if (load_ptr >= size) load_ptr = 0;
                    if (!written[load_ptr]) begin
                        written[load_ptr] = 1'b1;
                        unwritten--;
                    end
                    frame_mem[load_ptr] = pix;
                    load_ptr++;
                    if (load_ptr >= size) load_ptr = 0;
                end
                KIND_EMIT: begin
                    if (emit_ptr >= size) emit_ptr = 0;
                    e.pixel = filter_at(emit_ptr);
                    e.last  = (emit_ptr == size - 1);
                    pending_pixels.push_back(e);
                    emit_ptr++;
                    if (emit_ptr >= size) emit_ptr = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [PIX_W-1:0] pix, logic last);
            t_out_pixel e;
            n_checked++;
            if (pending_pixels.size() == 0) begin
                $error("result %0d with nothing pending: out_pixel %0d, last_pixel %0d",
                       n_checked, pix, last);
                n_errors++;
                return;
            end
            e = pending_pixels.pop_front();
            if (pix !== e.pixel) begin
                $error("result %0d out_pixel: expected %0d, actual %0d", n_checked, e.pixel, pix);
                n_errors++;
            end
            if (last !== e.last) begin
                $error("result %0d last_pixel: expected %0d, actual %0d", n_checked, e.last, last);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cv2d_in_if  in_ch ();
    cv2d_out_if out_ch ();
    cv2d_cfg_if cfg_ch ();

    conv_frame_checker frame_check;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int n_items       = 0;
    int n_settings    = 0;

    convolve_2d_clamped_edges dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Generous cap on the whole run
    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    // Result side: check each transfer, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            frame_check.check_result(out_ch.out_pixel, out_ch.last_pixel);
        out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // One item transfer, with random sender gaps ahead of it
    task automatic put_item(logic [KIND_W-1:0] kind, logic [TAP_IDX_W-1:0] tap,
                            logic signed [COEF_W-1:0] coeff, logic [PIX_W-1:0] pix);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= kind;
        in_ch.tap_index   <= tap;
        in_ch.coeff_value <= coeff;
        in_ch.pixel_value <= pix;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        frame_check.note_item(kind, tap, coeff, pix);
        n_items++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        frame_check.note_config(idx, data);
    endtask

    // Full register setting; radius upper bits carry noise the block must drop
    task automatic write_regs(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                              logic [RADIUS_W-1:0] r, bit with_spare);
        logic [CFG_DATA_W-1:0] rdata;
        rdata = CFG_DATA_W'($urandom_range(0, 511));
        rdata[RADIUS_W-1:0] = r;
        cfg_write(REG_WIDTH, w);
        if (with_spare) cfg_write(REG_NONE, CFG_DATA_W'($urandom_range(0, 511)));
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_RADIUS, rdata);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    task automatic wait_results();
        in_ch.valid <= 1'b0;
        while (frame_check.pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Block idle: no result pending and any tap or pixel transfer retired
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coeff();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return COEF_W'(int'($urandom_range(0, 12000)) - 3000);
        if (sel < 85) return COEF_W'($urandom_range(0, 262143));
        case (sel % 5)
            0:       return '0;
            1:       return COEF_ONE;
            2:       return -COEF_ONE;
            3:       return COEF_MIN;
            default: return COEF_MAX;
        endcase
    endfunction

    // Tap slot inside the window of the current radius
    function automatic logic [TAP_IDX_W-1:0] pick_live_tap();
        int r;
        r = frame_check.live_radius();
        return TAP_IDX_W'($urandom_range(0, 2 * r) * KSIDE + $urandom_range(0, 2 * r));
    endfunction

    initial begin
        int                       phase, budget, n, k, sel;
        logic [CFG_DATA_W-1:0]    w, h;
        logic [RADIUS_W-1:0]      r;
        logic [KIND_W-1:0]        kind;
        logic [TAP_IDX_W-1:0]     tap;
        logic signed [COEF_W-1:0] coeff;
        logic [PIX_W-1:0]         pix;

        frame_check = new();
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.kind        <= KIND_COEF;
        in_ch.tap_index   <= '0;
        in_ch.coeff_value <= '0;
        in_ch.pixel_value <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_WIDTH;
        cfg_ch.data       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: 3x2 frame at radius 2, so most taps hit replicated borders
        write_regs(9'd3, 9'd2, 2'd2, 1'b1);
        put_item(KIND_COEF, 5'd0, COEF_MIN, 8'd0);
        put_item(KIND_COEF, TAP_IDX_W'(NTAPS - 1), COEF_MAX, 8'd0);
        put_item(KIND_COEF, 5'd12, COEF_ONE, 8'd0);
        put_item(KIND_COEF, 5'd31, COEF_ONE, 8'd255);    // slot out of range: dropped
        put_item(KIND_COEF, TAP_IDX_W'(NTAPS), COEF_MIN, 8'd0);  // first slot past the table
        put_item(KIND_NONE, 5'd31, COEF_MAX, 8'd255);    // spare kind: dropped
        put_item(KIND_PIXEL, 5'd0, '0, 8'd0);
        put_item(KIND_PIXEL, 5'd0, '0, 8'd255);
        put_item(KIND_PIXEL, 5'd0, '0, 8'd128);
        put_item(KIND_PIXEL, 5'd0, '0, 8'd1);
        put_item(KIND_PIXEL, 5'd0, '0, 8'd254);
        put_item(KIND_PIXEL, 5'd0, '0, 8'd77);
        repeat (7) put_item(KIND_EMIT, 5'd0, '0, 8'd0);  // wraps past the last pixel
        put_item(KIND_PIXEL, 5'd0, '0, 8'd200);          // load pointer wrapped to origin
        put_item(KIND_COEF, 5'd6, -COEF_ONE, 8'd0);
        repeat (2) put_item(KIND_EMIT, 5'd0, '0, 8'd0);

        // Random phases, each with its own setting and idling mode
        budget = 0;
        phase  = 0;
        while (budget < RANDOM_ITEMS) begin
            settle();
            case (phase % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 87; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 87; end
                default: begin in_idle_pct = 8; out_stall_pct = 8; end
            endcase
            case (phase)
                0: write_regs(9'd256, 9'd1, 2'd2, 1'b0);
                1: write_regs(9'd1, 9'd256, 2'd0, 1'b1);
                2: write_regs(9'd0, 9'd0, 2'd3, 1'b0);    // zero sizes act as one
                3: write_regs(9'd511, 9'd1, 2'd1, 1'b1);  // oversize width clamps
                4: write_regs(9'd1, 9'd300, 2'd2, 1'b0);
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        w = CFG_DATA_W'($urandom_range(13, 256));
                        h = 9'd1;
                    end else begin
                        w = CFG_DATA_W'($urandom_range(1, 12));
                        h = CFG_DATA_W'($urandom_range(1, 12));
                    end
                    r = RADIUS_W'($urandom_range(0, 3));
                    write_regs(w, h, r, $urandom_range(0, 3) == 0);
                end
            endcase

            repeat ($urandom_range(2, 8)) begin
                put_item(KIND_COEF, pick_live_tap(), pick_coeff(),
                         PIX_W'($urandom_range(0, 255)));
                budget++;
            end

            n = frame_check.unwritten + frame_check.unwritten / 8 + $urandom_range(40, 90);
            for (k = 0; k < n; k++) begin
                // hold off until the block has drained every result
                if (phase % 3 == 1 && k == n / 2) wait_results();
                tap   = TAP_IDX_W'($urandom_range(0, 31));
                coeff = COEF_W'($urandom_range(0, 262143));
                pix   = PIX_W'($urandom_range(0, 255));
                sel   = $urandom_range(0, 99);
                // emits only once the whole frame is loaded
                if (frame_check.unwritten != 0 && sel < 94) sel = 50;
                if (sel < 45) begin
                    kind = KIND_EMIT;
                end else if (sel < 72) begin
                    kind = KIND_PIXEL;
                end else if (sel < 94) begin
                    kind  = KIND_COEF;
                    tap   = pick_live_tap();
                    coeff = pick_coeff();
                end else if (sel < 97) begin
                    kind = KIND_COEF;
                end else begin
                    kind = KIND_NONE;
                end
                put_item(kind, tap, coeff, pix);
                if (kind != KIND_NONE) budget++;
            end
            phase++;
        end

        settle();
        $display("Run covered %0d input transfers over %0d register settings, sides 1 to 256.",
                 n_items, n_settings);
        $display("%0d filtered pixels compared, %0d mismatches.",
                 frame_check.n_checked, frame_check.n_errors);
        if (frame_check.n_errors == 0 && frame_check.pending_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
